// ----- hdl/sgmpa_pkg.sv -----
// ============================================================================
// sgmpa_pkg
// Shared constants, types and register codes for the SGM path aggregation.
// ============================================================================
package sgmpa_pkg;

    localparam int MAX_DISPARITIES = 128;
    localparam int DISP_W          = $clog2(MAX_DISPARITIES);
    localparam int CNT_W           = DISP_W + 1;
    localparam int COST_W          = 16;
    localparam int COUNT_W         = 8;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_IDX_W       = 2;
    // width in which the disparity count and the counter are compared
    localparam int NCMP_W          = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    localparam logic [COST_W-1:0]  COST_CEIL        = '1;
    localparam logic [COUNT_W-1:0] RST_DISP_COUNT   = 8'd64;
    localparam logic [COST_W-1:0]  RST_PENALTY_SMALL = 16'd10;
    localparam logic [COST_W-1:0]  RST_PENALTY_LARGE = 16'd120;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISP_COUNT    = 2'd0,
        CFG_PENALTY_SMALL = 2'd1,
        CFG_PENALTY_LARGE = 2'd2
    } cfg_reg_t;

    // operands of one path cost evaluation
    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              start;
        logic              first;
        logic              last;
        logic [COST_W-1:0] old;
        logic [COST_W-1:0] upper;
        logic [COST_W-1:0] lower;
        logic [COST_W-1:0] prev_min;
        logic [COST_W-1:0] p1;
        logic [COST_W-1:0] p2;
    } calc_req_t;

endpackage

// ----- hdl/sgmpa_cost_if.sv -----
// ============================================================================
// sgmpa_cost_if
// Matching cost request channel: one cost per disparity.
// ============================================================================
interface sgmpa_cost_if
    import sgmpa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [COST_W-1:0] match_cost;
    logic              path_start;

    modport source (output valid, output match_cost, output path_start, input ready);
    modport sink   (input valid, input match_cost, input path_start, output ready);
endinterface

// ----- hdl/sgmpa_path_if.sv -----
// ============================================================================
// sgmpa_path_if
// Path cost request channel: one aggregated cost per disparity.
// ============================================================================
interface sgmpa_path_if
    import sgmpa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [COST_W-1:0] path_cost;
    logic              pixel_done;

    modport source (output valid, output path_cost, output pixel_done, input ready);
    modport sink   (input valid, input path_cost, input pixel_done, output ready);
endinterface

// ----- hdl/sgmpa_cost_calc.sv -----
// ============================================================================
// sgmpa_cost_calc
// Path cost for one disparity: C + min(neighbors, penalties) - previous min.
// ============================================================================
module sgmpa_cost_calc
    import sgmpa_pkg::*;
(
    input  calc_req_t         req,
    output logic [COST_W-1:0] result
);

    logic [COST_W:0]   lower_sum;
    logic [COST_W:0]   upper_sum;
    logic [COST_W:0]   jump_sum;
    logic [COST_W:0]   best;
    logic [COST_W+1:0] total;
    logic [COST_W+1:0] diff;

    always_comb
    begin
        lower_sum = {1'b0, req.lower} + {1'b0, req.p1};
        upper_sum = {1'b0, req.upper} + {1'b0, req.p1};
        jump_sum  = {1'b0, req.prev_min} + {1'b0, req.p2};

        best = {1'b0, req.old};
        if (!req.first && lower_sum < best)
        begin
            best = lower_sum;
        end
        if (!req.last && upper_sum < best)
        begin
            best = upper_sum;
        end
        if (jump_sum < best)
        begin
            best = jump_sum;
        end

        total = {2'b00, req.cost} + {1'b0, best};
        diff  = total - {2'b00, req.prev_min};

        if (req.start)
        begin
            result = req.cost;
        end
        else if (total < {2'b00, req.prev_min})
        begin
            result = '0;
        end
        else if (diff > {2'b00, COST_CEIL})
        begin
            result = COST_CEIL;
        end
        else
        begin
            result = diff[COST_W-1:0];
        end
    end

endmodule

// ----- hdl/sgm_path_cost_aggregation_top.sv -----
// ============================================================================
// sgm_path_cost_aggregation_top
// SGM path cost aggregation along one path, vector kept in a local RAM.
// ============================================================================
//  channel      | dir | payload                       | notes
//  -------------+-----+-------------------------------+---------------------
//  cost_stream  | in  | match_cost[15:0], path_start  | disparity 0 first
//  path_stream  | out | path_cost[15:0], pixel_done   | one per request
//  cfg_*        | in  | cfg_index[1:0], cfg_data[15:0]| write only, idle time
//
//  One request per clock sustained while the output is not stalled; the RAM
//  is read into the compute stage when a request is accepted, and the result
//  is computed there and loaded into the output register, where it is taken.
//  The path vector RAM has two read ports and one write port; the write of
//  the request in compute is forwarded to a read issued in the same cycle.
//  Reset clears the counter and sets minima to COST_CEIL; the RAM is not reset.
//  A stalled output holds the compute stage, which holds the input.
// ============================================================================
module sgm_path_cost_aggregation_top
    import sgmpa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    sgmpa_cost_if.sink            cost_stream,
    sgmpa_path_if.source          path_stream
);

    logic [COST_W-1:0] vec_mem [MAX_DISPARITIES];

    logic [COUNT_W-1:0] count_reg;
    logic [COST_W-1:0]  p1_reg;
    logic [COST_W-1:0]  p2_reg;

    logic [DISP_W-1:0]  cnt_reg;
    logic [DISP_W-1:0]  cnt_next;

    logic               s1_valid_reg;
    logic [COST_W-1:0]  s1_cost_reg;
    logic               s1_start_reg;
    logic [DISP_W-1:0]  s1_d_reg;
    logic               s1_last_reg;

    logic [COST_W-1:0]  rd_a_reg;
    logic [COST_W-1:0]  rd_b_reg;
    logic               fwd_a_reg;
    logic               fwd_b_reg;
    logic [COST_W-1:0]  fwd_val_reg;

    logic [COST_W-1:0]  hold_reg;
    logic [COST_W-1:0]  prev_min_reg;
    logic [COST_W-1:0]  run_min_reg;
    logic [COST_W-1:0]  run_min_next;

    logic               out_valid_reg;
    logic [COST_W-1:0]  out_cost_reg;
    logic               out_done_reg;

    logic               accept;
    logic               s1_fire;
    logic [NCMP_W-1:0]  count_ext;
    logic [NCMP_W-1:0]  n_eff;
    logic               acc_last;
    logic [DISP_W-1:0]  addr_a;
    logic [DISP_W-1:0]  addr_b;
    logic [COST_W-1:0]  old_val;
    logic [COST_W-1:0]  upper_val;
    calc_req_t          calc_req;
    logic [COST_W-1:0]  result;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= RST_DISP_COUNT;
            p1_reg    <= RST_PENALTY_SMALL;
            p2_reg    <= RST_PENALTY_LARGE;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_DISP_COUNT:    count_reg <= cfg_data[COUNT_W-1:0];
                CFG_PENALTY_SMALL: p1_reg    <= cfg_data[COST_W-1:0];
                CFG_PENALTY_LARGE: p2_reg    <= cfg_data[COST_W-1:0];
                default:           ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign s1_fire           = s1_valid_reg && (!out_valid_reg || path_stream.ready);
    assign cost_stream.ready = !s1_valid_reg || s1_fire;
    assign accept            = cost_stream.valid && cost_stream.ready;

    // ---------------- disparity counter / read addresses ----------------
    always_comb
    begin
        count_ext = NCMP_W'(count_reg);
        if (count_reg == '0)
        begin
            n_eff = NCMP_W'(1);
        end
        else if (count_ext > NCMP_W'(MAX_DISPARITIES))
        begin
            n_eff = NCMP_W'(MAX_DISPARITIES);
        end
        else
        begin
            n_eff = count_ext;
        end
        acc_last = (NCMP_W'(cnt_reg) + NCMP_W'(1)) >= n_eff;
        addr_a   = cnt_reg;
        addr_b   = cnt_reg + DISP_W'(1);
        cnt_next = acc_last ? '0 : addr_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            cnt_reg <= cnt_next;
        end
    end

    // ---------------- path vector RAM ----------------
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            vec_mem[s1_d_reg] <= result;
        end
        if (accept)
        begin
            rd_a_reg <= vec_mem[addr_a];
            rd_b_reg <= vec_mem[addr_b];
        end
    end

    // write in the same cycle as the read returns stale data: forward it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_a_reg <= 1'b0;
            fwd_b_reg <= 1'b0;
        end
        else if (accept)
        begin
            fwd_a_reg <= s1_fire && (s1_d_reg == addr_a);
            fwd_b_reg <= s1_fire && (s1_d_reg == addr_b);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_val_reg <= result;
        end
    end

    // ---------------- compute stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cost_reg  <= cost_stream.match_cost;
            s1_start_reg <= cost_stream.path_start;
            s1_d_reg     <= cnt_reg;
            s1_last_reg  <= acc_last;
        end
    end

    assign old_val   = fwd_a_reg ? fwd_val_reg : rd_a_reg;
    assign upper_val = fwd_b_reg ? fwd_val_reg : rd_b_reg;

    always_comb
    begin
        calc_req.cost     = s1_cost_reg;
        calc_req.start    = s1_start_reg;
        calc_req.first    = (s1_d_reg == '0);
        calc_req.last     = s1_last_reg;
        calc_req.old      = old_val;
        calc_req.upper    = upper_val;
        calc_req.lower    = hold_reg;
        calc_req.prev_min = prev_min_reg;
        calc_req.p1       = p1_reg;
        calc_req.p2       = p2_reg;
    end

    sgmpa_cost_calc u_calc (
        .req    (calc_req),
        .result (result)
    );

    assign run_min_next = (result < run_min_reg) ? result : run_min_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg     <= '0;
            prev_min_reg <= COST_CEIL;
            run_min_reg  <= COST_CEIL;
        end
        else if (s1_fire)
        begin
            hold_reg <= old_val;
            if (s1_last_reg)
            begin
                prev_min_reg <= run_min_next;
                run_min_reg  <= COST_CEIL;
            end
            else
            begin
                run_min_reg <= run_min_next;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (path_stream.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_cost_reg <= result;
            out_done_reg <= s1_last_reg;
        end
    end

    assign path_stream.valid      = out_valid_reg;
    assign path_stream.path_cost  = out_cost_reg;
    assign path_stream.pixel_done = out_done_reg;

`ifndef SYNTH
    a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("compute stage fired without filling the output register");

    a_counter_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && acc_last) |=> (cnt_reg == '0))
        else $error("disparity counter did not wrap after the last disparity");

    a_start_passes_cost: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_start_reg) |-> (result == s1_cost_reg))
        else $error("path start did not pass the matching cost through");

    a_min_only_at_pixel_end: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_fire && s1_last_reg) |=> $stable(prev_min_reg))
        else $error("previous minimum changed inside a pixel");
`endif

endmodule
